[rtl/tmps_pkg.sv]
package tmps_pkg;

	localparam int MAX_ROWS   = 256;
	localparam int VALUE_BITS = 16;
	localparam int SUM_W      = 32;
	localparam int CFG_W      = 9;
	localparam int CNT_W      = $clog2(MAX_ROWS + 1);
	localparam int IDX_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int WIDE_W     = ((CFG_W > CNT_W) ? CFG_W : CNT_W) + 1;

	typedef struct packed {
		logic             ins;
		logic             pop1;
		logic             pop2;
		logic [IDX_W-1:0] ins_idx;
	} cell_ctrl_t;

	typedef struct packed {
		logic             bottom;
		logic             first;
		logic             done;
		logic [IDX_W-1:0] ins_idx;
	} seq_stat_t;

endpackage

[rtl/triangle_min_path_sum.sv]
// Minimum top-to-bottom path sum of a triangle, fed bottom row first, each row
// left to right, one entry per transfer. An entry is taken in every cycle; the
// input stalls only while a finished sum sits in the output register and is not
// taken. The sum shows in the cycle after the top entry is taken. Row sums
// live in a chain of MAX_ROWS cells that works as a queue: each entry pops the
// sums it consumes from the head and the new sum is dropped into the tail cell,
// so one add, one compare and saturation to 32 bits set the cycle. Writing
// num_rows (0 acts as 1, larger than MAX_ROWS acts as MAX_ROWS) drops any partly
// fed triangle; write it only while the block is idle. No clearing pass is run.
module triangle_min_path_sum
	import tmps_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         num_rows_we,
	input  logic [CFG_W-1:0]             num_rows,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [SUM_W-1:0]      min_sum
);

	logic                    accept;
	seq_stat_t               stat;
	cell_ctrl_t              cctl;
	logic signed [SUM_W-1:0] cell_q [MAX_ROWS];
	logic signed [SUM_W-1:0] head0;
	logic signed [SUM_W-1:0] head1;
	logic signed [SUM_W-1:0] left;
	logic signed [SUM_W-1:0] right;
	logic signed [SUM_W-1:0] best;
	logic signed [SUM_W:0]   wide_sum;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] right_nbr_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] min_sum_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign min_sum   = min_sum_q;

	tmps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cfg_we   (num_rows_we),
		.cfg_data (num_rows),
		.stat     (stat)
	);

	assign head0 = cell_q[0];
	generate
		if (MAX_ROWS > 1) begin : g_head1
			assign head1 = cell_q[1];
		end else begin : g_head1_none
			assign head1 = '0;
		end
	endgenerate

	always_comb begin
		left     = stat.first ? head0 : right_nbr_q;
		right    = stat.first ? head1 : head0;
		best     = (right < left) ? right : left;
		wide_sum = (SUM_W + 1)'(value) + (SUM_W + 1)'(best);
		if (stat.bottom) begin
			sum = SUM_W'(value);
		end else if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
			sum = wide_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum = wide_sum[SUM_W-1:0];
		end
		cctl.ins     = accept;
		cctl.pop1    = !stat.bottom && !stat.first;
		cctl.pop2    = !stat.bottom && stat.first;
		cctl.ins_idx = stat.ins_idx;
	end

	genvar k;
	generate
		for (k = 0; k < MAX_ROWS; k++) begin : g_cell
			logic signed [SUM_W-1:0] n1;
			logic signed [SUM_W-1:0] n2;
			if (k + 1 < MAX_ROWS) begin : g_n1
				assign n1 = cell_q[k+1];
			end else begin : g_n1_end
				assign n1 = '0;
			end
			if (k + 2 < MAX_ROWS) begin : g_n2
				assign n2 = cell_q[k+2];
			end else begin : g_n2_end
				assign n2 = '0;
			end
			tmps_cell u_cell (
				.clk    (clk),
				.ctl    (cctl),
				.idx    (IDX_W'(k)),
				.nbr1   (n1),
				.nbr2   (n2),
				.sum_in (sum),
				.sum_q  (cell_q[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_nbr_q <= '0;
		end else if (num_rows_we) begin
			right_nbr_q <= '0;
		end else if (accept) begin
			if (stat.done) begin
				right_nbr_q <= '0;
			end else if (!stat.bottom) begin
				right_nbr_q <= right;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && stat.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && stat.done) begin
			min_sum_q <= sum;
		end
	end

endmodule

[rtl/tmps_cell.sv]
module tmps_cell
	import tmps_pkg::*;
(
	input  logic                    clk,
	input  cell_ctrl_t              ctl,
	input  logic [IDX_W-1:0]        idx,
	input  logic signed [SUM_W-1:0] nbr1,
	input  logic signed [SUM_W-1:0] nbr2,
	input  logic signed [SUM_W-1:0] sum_in,
	output logic signed [SUM_W-1:0] sum_q
);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (ctl.ins_idx == idx) begin
				sum_q <= sum_in;
			end else if (ctl.pop2) begin
				sum_q <= nbr2;
			end else if (ctl.pop1) begin
				sum_q <= nbr1;
			end
		end
	end

endmodule

[rtl/tmps_ctrl.sv]
module tmps_ctrl
	import tmps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	output seq_stat_t        stat
);

	logic [CNT_W-1:0]  num_rows_q;
	logic [CNT_W-1:0]  row_left_q;
	logic [IDX_W-1:0]  col_q;
	logic [CNT_W-1:0]  count_q;
	logic [WIDE_W-1:0] cfg_wide;
	logic [CNT_W-1:0]  cfg_sat;
	logic [CNT_W-1:0]  pop;
	logic              row_end;

	always_comb begin
		cfg_wide = WIDE_W'(cfg_data);
		if (cfg_wide == '0) begin
			cfg_sat = CNT_W'(1);
		end else if (cfg_wide > WIDE_W'(MAX_ROWS)) begin
			cfg_sat = CNT_W'(MAX_ROWS);
		end else begin
			cfg_sat = CNT_W'(cfg_wide);
		end
	end

	always_comb begin
		stat.bottom = (row_left_q >= num_rows_q);
		stat.first  = (col_q == '0);
		row_end     = ((CNT_W'(col_q) + CNT_W'(1)) >= row_left_q);
		stat.done   = row_end && (row_left_q <= CNT_W'(1));
		if (stat.bottom) begin
			pop = '0;
		end else if (stat.first) begin
			pop = CNT_W'(2);
		end else begin
			pop = CNT_W'(1);
		end
		stat.ins_idx = IDX_W'(count_q - pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CNT_W'(1);
			row_left_q <= CNT_W'(1);
			col_q      <= '0;
			count_q    <= '0;
		end else if (cfg_we) begin
			num_rows_q <= cfg_sat;
			row_left_q <= cfg_sat;
			col_q      <= '0;
			count_q    <= '0;
		end else if (accept) begin
			if (stat.done) begin
				row_left_q <= num_rows_q;
				col_q      <= '0;
				count_q    <= '0;
			end else begin
				count_q <= count_q - pop + CNT_W'(1);
				if (row_end) begin
					row_left_q <= row_left_q - CNT_W'(1);
					col_q      <= '0;
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end
		end
	end

endmodule
